>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the range generator.
// Each macro expects aclk and aresetn in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/lrg_pkg.sv
`timescale 1ns / 1ps
// Types and constants of the Lehmer range generator.
// No dependencies; imported by lehmer_range_generator_unit, lrg_draw_checker and tb_top.
package lrg_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned MULT_W     = 29;
    localparam int unsigned PROD_W     = DATA_W + MULT_W;
    localparam int unsigned FOLD_W     = DATA_W + 2;
    localparam int unsigned CNT_W      = $clog2(DATA_W);
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned REG_IDX_W  = CFG_ADDR_W - 2;

    localparam logic [MULT_W-1:0]    LEHMER_MULT  = 29'd279470273;
    localparam logic [DATA_W-1:0]    LEHMER_PRIME = 32'hFFFF_FFFB;
    localparam logic [DATA_W-1:0]    SEED_RESET   = 32'd1;
    localparam logic [CNT_W-1:0]     LAST_BIT     = CNT_W'(DATA_W - 1);
    localparam logic [REG_IDX_W-1:0] REG_SEED     = '0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FOLD,
        ST_REDUCE,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic out_load;
        logic div_run;
    } ctrl_t;

endpackage

>>> sv/lehmer_range_generator_unit.sv
`timescale 1ns / 1ps
// Lehmer generator (modulus 2^32-5) with a bit-serial remainder by the range span.
// Depends on lrg_pkg and assert_macros.svh.
//
//  channel | ports                                   | role
//  --------+-----------------------------------------+------------------------
//  s_      | s_valid s_ready s_range_min s_range_max | range request beats in
//  m_      | m_valid m_ready m_value m_empty_range   | result beats out
//          | m_new_state                             |
//  apb     | psel penable pwrite paddr pwdata prdata | seed register
//
// One item runs through the idle state that takes its request, one multiply, two
// folding steps of the 2^32-5 reduction, 32 steps of a radix-2 restoring remainder
// (one quotient bit per cycle) and a done step that loads the output register; only
// then does the idle state take the next request.
// A finished beat waits in the output register while the next request runs; that one
// holds in its done step until the register frees. Reset and seed writes load the state.
module lehmer_range_generator_unit
    import lrg_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [DATA_W-1:0] s_range_min,
    input  logic signed [DATA_W-1:0] s_range_max,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [DATA_W-1:0] m_value,
    output logic                    m_empty_range,
    output logic [DATA_W-1:0]       m_new_state,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CFG_ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    `include "assert_macros.svh"

    state_t              state_reg, state_next;
    ctrl_t               ctrl;
    logic [DATA_W-1:0]   seed_reg;
    logic [DATA_W-1:0]   gen_state_reg;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [FOLD_W-1:0]   fold_reg, fold_next;
    logic [DATA_W:0]     red_sum;
    logic [DATA_W-1:0]   red_next;
    logic [DATA_W-1:0]   span_reg;
    logic [DATA_W-1:0]   lo_reg;
    logic                empty_reg;
    logic [DATA_W-1:0]   quo_reg;
    logic [DATA_W-1:0]   rem_reg, rem_next;
    logic [DATA_W:0]     rem_shift;
    logic [CNT_W-1:0]    bit_cnt_reg;
    logic                m_valid_reg;
    logic [DATA_W-1:0]   m_value_reg;
    logic                m_empty_reg;
    logic [DATA_W-1:0]   m_new_state_reg;
    logic                seed_wr;
    logic                in_beat;
    logic                reduce_now;
    logic                div_last;
    logic                div_live;

    assign pready  = 1'b1;
    assign seed_wr = psel && penable && pwrite && pready
                     && (paddr[CFG_ADDR_W-1:2] == REG_SEED);
    assign prdata  = (paddr[CFG_ADDR_W-1:2] == REG_SEED) ? seed_reg : '0;

    assign s_ready = ctrl.in_ready;
    assign in_beat = s_valid && ctrl.in_ready;

    // Product, then two folds using 2^32 = 5 mod the prime.
    assign prod_next = {{MULT_W{1'b0}}, gen_state_reg} * {{DATA_W{1'b0}}, LEHMER_MULT};
    assign fold_next = {2'b00, prod_reg[DATA_W-1:0]}
                     + FOLD_W'({prod_reg[PROD_W-1:DATA_W], 2'b00})
                     + FOLD_W'(prod_reg[PROD_W-1:DATA_W]);
    assign red_sum   = {1'b0, fold_reg[DATA_W-1:0]}
                     + (DATA_W+1)'({fold_reg[FOLD_W-1:DATA_W], 2'b00})
                     + (DATA_W+1)'(fold_reg[FOLD_W-1:DATA_W]);
    assign red_next  = (red_sum >= {1'b0, LEHMER_PRIME})
                     ? DATA_W'(red_sum - {1'b0, LEHMER_PRIME})
                     : red_sum[DATA_W-1:0];

    // One restoring remainder step.
    assign rem_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign rem_next  = (rem_shift >= {1'b0, span_reg})
                     ? DATA_W'(rem_shift - {1'b0, span_reg})
                     : rem_shift[DATA_W-1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_beat) state_next = ST_MUL;
            ST_MUL:    state_next = ST_FOLD;
            ST_FOLD:   state_next = ST_REDUCE;
            ST_REDUCE: state_next = ST_DIV;
            ST_DIV:    if (bit_cnt_reg == LAST_BIT) state_next = ST_DONE;
            ST_DONE:   if (ctrl.out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:   ctrl.in_ready = 1'b1;
            ST_DIV:    ctrl.div_run  = 1'b1;
            ST_DONE:   ctrl.out_load = !m_valid_reg || m_ready;
            default:   ctrl = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            seed_reg      <= SEED_RESET;
            gen_state_reg <= SEED_RESET;
            m_valid_reg   <= 1'b0;
            bit_cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (seed_wr) begin
                seed_reg      <= pwdata;
                gen_state_reg <= pwdata;
            end else if (state_reg == ST_REDUCE) begin
                gen_state_reg <= red_next;
            end
            if (state_reg == ST_REDUCE) begin
                bit_cnt_reg <= '0;
            end else if (ctrl.div_run) begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end
            if (ctrl.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            lo_reg    <= s_range_min;
            span_reg  <= s_range_max - s_range_min;
            empty_reg <= (s_range_max == s_range_min);
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= prod_next;
        end
        if (state_reg == ST_FOLD) begin
            fold_reg <= fold_next;
        end
        if (state_reg == ST_REDUCE) begin
            quo_reg <= red_next;
            rem_reg <= '0;
        end else if (ctrl.div_run) begin
            quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (ctrl.out_load) begin
            m_value_reg     <= empty_reg ? lo_reg : rem_reg + lo_reg;
            m_empty_reg     <= empty_reg;
            m_new_state_reg <= gen_state_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_value       = m_value_reg;
    assign m_empty_range = m_empty_reg;
    assign m_new_state   = m_new_state_reg;

    assign reduce_now = (state_reg == ST_REDUCE) && !seed_wr;
    assign div_last   = (state_reg == ST_DIV) && (bit_cnt_reg == LAST_BIT);
    assign div_live   = (state_reg == ST_DIV) && (span_reg != '0);

    `ASSERT_NEXT(a_state_reduced, reduce_now, gen_state_reg < LEHMER_PRIME, "state not reduced")
    `ASSERT_ALWAYS(a_rem_below_span, !div_live || rem_reg < span_reg, "remainder reached span")
    `ASSERT_NEXT(a_div_ends, div_last, state_reg == ST_DONE, "remainder did not finish")
    `ASSERT_ALWAYS(a_out_from_done, !$rose(m_valid_reg) || $past(state_reg) == ST_DONE, "stray beat")

endmodule

>>> sim/lrg_draw_checker.sv
`timescale 1ns / 1ps
// Scoreboard for lehmer_range_generator_unit: tracks seed writes, predicts every draw
// and compares each result beat field by field. Depends on lrg_pkg.
module lrg_draw_checker
    import lrg_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_range_min,
    input  logic signed [DATA_W-1:0] s_range_max,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [DATA_W-1:0] m_value,
    input  logic                     m_empty_range,
    input  logic [DATA_W-1:0]        m_new_state,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [CFG_ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output int                       pending,
    output int                       mismatches
);

    localparam int MAX_REPORTS = 40;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic              empty;
        logic [DATA_W-1:0] state;
    } draw_t;

    draw_t             expected_draws[$];
    logic [DATA_W-1:0] gen_state;

    function automatic logic [DATA_W-1:0] lehmer_advance(input logic [DATA_W-1:0] cur);
        logic [63:0] prod;
        prod = 64'(cur) * 64'(LEHMER_MULT);
        return DATA_W'(prod % 64'(LEHMER_PRIME));
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (mismatches < MAX_REPORTS) begin
            $display("%0t ns: draw mismatch on %s: got %h, want %h", $time, what, got, want);
        end
        mismatches++;
    endtask

    always @(posedge aclk) begin
        draw_t             want;
        logic [DATA_W-1:0] span;
        if (!aresetn) begin
            gen_state = SEED_RESET;
            expected_draws.delete();
            mismatches = 0;
            pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready
                && paddr[CFG_ADDR_W-1:2] == REG_SEED) begin
                gen_state = pwdata;
            end
            if (m_valid && m_ready) begin
                if (expected_draws.size() == 0) begin
                    report_mismatch("unexpected beat", m_value, '0);
                end else begin
                    want = expected_draws.pop_front();
                    if (m_value !== want.value) begin
                        report_mismatch("value", m_value, want.value);
                    end
                    if (m_empty_range !== want.empty) begin
                        report_mismatch("empty_range", DATA_W'(m_empty_range),
                                        DATA_W'(want.empty));
                    end
                    if (m_new_state !== want.state) begin
                        report_mismatch("new_state", m_new_state, want.state);
                    end
                end
            end
            if (s_valid && s_ready) begin
                gen_state  = lehmer_advance(gen_state);
                span       = s_range_max - s_range_min;
                want.state = gen_state;
                want.empty = (span == '0);
                want.value = want.empty ? DATA_W'(s_range_min)
                                        : (gen_state % span) + DATA_W'(s_range_min);
                expected_draws.insert(expected_draws.size(), want);
            end
            pending <= expected_draws.size();
        end
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for lehmer_range_generator_unit: clock, reset, seed writes, range beats
// under several idle and stall mixes, and the verdict. Depends on lrg_pkg, the unit
// and lrg_draw_checker.
module tb_top
    import lrg_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 45;
    localparam int PHASE_BEATS  = 400;

    localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_range_min   = '0;
    logic signed [DATA_W-1:0] s_range_max   = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic signed [DATA_W-1:0] m_value;
    logic                     m_empty_range;
    logic [DATA_W-1:0]        m_new_state;
    logic                     psel          = 1'b0;
    logic                     penable       = 1'b0;
    logic                     pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0]    paddr         = '0;
    logic [DATA_W-1:0]        pwdata        = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    int pending;
    int mismatches;
    int cycle_count = 0;
    int src_idle    = 0;
    int dst_stall   = 0;

    always #6 aclk = ~aclk;

    lehmer_range_generator_unit dut (.*);

    lrg_draw_checker draw_check (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        m_ready     <= ($urandom_range(99) >= dst_stall);
    end

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    task automatic send_range(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_range_min <= lo;
        s_range_max <= hi;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [DATA_W-1:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_SEED, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_random_range();
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        int                pick;
        lo   = $urandom;
        pick = $urandom_range(99);
        if (pick < 40) begin
            hi = lo + $urandom_range(1, 1000);
        end else if (pick < 50) begin
            hi = lo;
        end else if (pick < 60) begin
            hi = lo + (32'd1 << $urandom_range(31));
        end else if (pick < 70) begin
            hi = lo - $urandom_range(1, 1000);
        end else begin
            hi = $urandom;
        end
        send_range(lo, hi);
    endtask

    task automatic random_phase(input int src, input int dst);
        src_idle  = src;
        dst_stall = dst;
        for (int i = 0; i < PHASE_BEATS; i++) begin
            if (i == PHASE_BEATS / 2 && src != 0 && dst != 0) begin
                drain_results();
            end
            send_random_range();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset seed, extreme and special ranges
        send_range(INT_MIN, INT_MAX);
        send_range(INT_MAX, INT_MIN);
        send_range(32'd0, 32'd0);
        send_range(INT_MIN, INT_MIN);
        send_range(INT_MAX, INT_MAX);
        send_range(32'd0, 32'd1);
        send_range(32'hFFFF_FFFF, 32'd0);
        send_range(32'd0, 32'hFFFF_FFFF);
        send_range(32'd1, 32'd0);
        send_range(32'd0, INT_MIN);
        send_range(32'd5, 32'd10);
        send_range(32'hFFFF_FFF6, 32'd10);

        // zero seed holds the state at zero
        write_seed(32'd0);
        send_range(32'd100, 32'd200);
        send_range(INT_MIN, INT_MAX);
        send_range(32'd7, 32'd7);

        // seeds at, above and just below the prime
        write_seed(LEHMER_PRIME);
        send_range(32'd0, 32'hFFFF_FFFF);
        send_range(32'd3, 32'd1000);
        write_seed(32'hFFFF_FFFF);
        send_range(32'd0, 32'hFFFF_FFFF);
        send_range(INT_MIN, 32'd0);
        send_range(32'd0, INT_MAX);
        write_seed(LEHMER_PRIME - 32'd1);
        send_range(32'd0, 32'hFFFF_FFFF);
        send_range(32'hFFFF_FF00, 32'h0000_0100);

        write_seed($urandom);
        random_phase(0, 0);
        write_seed($urandom);
        random_phase(69, 0);
        write_seed(INT_MAX);
        random_phase(0, 69);
        write_seed($urandom);
        random_phase(9, 9);

        drain_results();
        if (mismatches == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
